@@ src/crcp_pkg.sv @@
// ----------------------------------------------------------------------------
// crcp_pkg
// Shared constants and types for the CRC codeword packer.
// ----------------------------------------------------------------------------
`default_nettype none

package crcp_pkg;

    localparam int DEF_MAX_GEN_BITS = 17;
    localparam int DEF_COUNT_BITS   = 24;

    // register reset values
    localparam int RST_GEN_POLY   = 11;
    localparam int RST_GEN_LEN    = 4;
    localparam int RST_WORD_MODE  = 0;
    localparam int RST_BYTE_COUNT = 1;

    localparam int NIBBLE_BITS = 4;
    localparam int BYTE_BITS   = 8;

    // configuration register index
    typedef enum logic [1:0] {
        REG_GEN_POLY   = 2'd0,
        REG_GEN_LEN    = 2'd1,
        REG_WORD_MODE  = 2'd2,
        REG_BYTE_COUNT = 2'd3
    } cfg_reg_t;

endpackage

`default_nettype wire

@@ src/crcp_encode.sv @@
// ----------------------------------------------------------------------------
// crcp_encode
// Single-pass encoder: CRC of one or two datawords, codeword assembly and
// byte slicing of the accumulated bit stream.
// ----------------------------------------------------------------------------
`default_nettype none

module crcp_encode
    import crcp_pkg::*;
#(
    parameter int MAX_GEN_BITS = DEF_MAX_GEN_BITS,
    parameter int GLW          = $clog2(MAX_GEN_BITS + 1),
    parameter int REM_BITS     = MAX_GEN_BITS - 1,
    parameter int SW           = 2 * BYTE_BITS - 1 + 2 * REM_BITS,
    parameter int MAXB         = SW / BYTE_BITS,
    parameter int NBW          = $clog2(MAXB + 2)
)
(
    input  wire logic [MAX_GEN_BITS-1:0]     gen_poly,
    input  wire logic [GLW-1:0]              gen_len,
    input  wire logic                        word_mode,
    input  wire logic                        start,
    input  wire logic [2:0]                  bc_lo,
    input  wire logic [6:0]                  acc_in,
    input  wire logic [2:0]                  cnt_in,
    input  wire logic [7:0]                  data_byte,
    output logic      [MAXB:0][7:0]          res_bytes,
    output logic      [NBW-1:0]              res_count,
    output logic      [6:0]                  acc_out,
    output logic      [2:0]                  cnt_out
);

    localparam int TW = $clog2(SW + 1);

    logic [GLW-1:0]          g_eff;
    logic [GLW-1:0]          rlen;
    logic [REM_BITS-1:0]     rmask;
    logic [REM_BITS-1:0]     gen_left;
    logic [GLW-1:0]          align_sh;
    logic [REM_BITS-1:0]     crc_a;
    logic [REM_BITS-1:0]     crc_b;
    logic [REM_BITS-1:0]     rem_a;
    logic [REM_BITS-1:0]     rem_b;
    logic [7:0]              dw_a;
    logic [SW-1:0]           word;
    logic [TW-1:0]           wbits;
    logic [2:0]              cw_lo;
    logic [5:0]              pad_prod;
    logic [2:0]              pad;
    logic [6:0]              acc_base;
    logic [2:0]              cnt_base;
    logic [SW-1:0]           stream;
    logic [TW-1:0]           total;
    logic [SW-1:0]           stream_left;
    logic [MAXB-1:0][7:0]    dbytes;
    logic [TW-4:0]           nbytes;

    // MSB-first LFSR form of the long division; the register is kept
    // left-aligned so its top bit is always the feedback tap
    function automatic logic [REM_BITS-1:0] crc_div(
        input logic [7:0]          dw,
        input logic                nibble,
        input logic [REM_BITS-1:0] gl
    );
        logic [REM_BITS-1:0] r;
        logic                fb;
        r = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (!(nibble && i >= NIBBLE_BITS))
            begin
                fb = dw[7-i] ^ r[REM_BITS-1];
                r  = (r << 1) ^ (fb ? gl : '0);
            end
        end
        return r;
    endfunction

    always_comb
    begin
        g_eff = gen_len;
        if (gen_len < GLW'(2))
            g_eff = GLW'(2);
        else if (gen_len > GLW'(MAX_GEN_BITS))
            g_eff = GLW'(MAX_GEN_BITS);
        rlen     = g_eff - GLW'(1);
        align_sh = GLW'(REM_BITS) - rlen;
        rmask    = ~({REM_BITS{1'b1}} << rlen);
        gen_left = (gen_poly[REM_BITS-1:0] & rmask) << align_sh;

        // nibble mode: first pass takes the high nibble
        dw_a  = word_mode ? {data_byte[7:4], 4'b0} : data_byte;
        crc_a = crc_div(dw_a, word_mode, gen_left);
        crc_b = crc_div({data_byte[3:0], 4'b0}, 1'b1, gen_left);
        rem_a = crc_a >> align_sh;
        rem_b = crc_b >> align_sh;

        if (word_mode)
        begin
            wbits = TW'(2 * NIBBLE_BITS) + TW'(rlen) + TW'(rlen);
            word  = (((SW'(data_byte[7:4]) << rlen) | SW'(rem_a))
                        << (TW'(NIBBLE_BITS) + TW'(rlen)))
                  | (SW'(data_byte[3:0]) << rlen) | SW'(rem_b);
            cw_lo = 3'(NIBBLE_BITS) + rlen[2:0];
        end
        else
        begin
            wbits = TW'(BYTE_BITS) + TW'(rlen);
            word  = (SW'(data_byte) << rlen) | SW'(rem_a);
            cw_lo = rlen[2:0];
        end

        // leading pad so the whole stream fills whole bytes
        pad_prod = 6'(bc_lo) * 6'(cw_lo);
        if (word_mode)
            pad_prod = pad_prod << 1;
        pad = 3'd0 - pad_prod[2:0];

        acc_base = start ? 7'd0 : acc_in;
        cnt_base = start ? pad : cnt_in;

        stream      = (SW'(acc_base) << wbits) | word;
        total       = TW'(cnt_base) + wbits;
        stream_left = stream << (TW'(SW) - total);
        nbytes      = total[TW-1:3];

        for (int k = 0; k < MAXB; k++)
            dbytes[k] = stream_left[SW-1-8*k -: 8];

        for (int k = 0; k <= MAXB; k++)
        begin
            if (start)
                res_bytes[k] = (k == 0) ? 8'(pad) : dbytes[(k == 0) ? 0 : k - 1];
            else
                res_bytes[k] = (k < MAXB) ? dbytes[(k < MAXB) ? k : 0] : 8'd0;
        end

        res_count = NBW'(nbytes) + NBW'(start);
        acc_out   = stream[6:0] & ~(7'h7f << total[2:0]);
        cnt_out   = total[2:0];
    end

endmodule

`default_nettype wire

@@ src/crc_codeword_packer.sv @@
// ----------------------------------------------------------------------------
// crc_codeword_packer
// CRC encoder with configurable generator; codewords packed MSB-first into
// bytes, each stream led by a pad-count header byte.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  s_axis    in         tvalid / tready    tdata[7:0] = data_byte
//  m_axis    out        tvalid / tready    tdata[7:0] = out_byte,
//                                          tuser = is_header, tlast = run_last
//  cfg       in         cfg_wr_en          cfg_index, cfg_wdata
//
//  An input byte is registered, encoded combinationally and loaded into a byte
//  buffer; the output drains that buffer one byte per cycle while m_axis_tready
//  is high, and an item yields 1 to 6 bytes, header included.
//  The next item is taken and encoded while the buffer is still draining.
//  Reset clears the stream counter, bit accumulator and handshake state and
//  loads the register defaults. Stalls on m_axis back up into s_axis.
// ----------------------------------------------------------------------------
`default_nettype none

module crc_codeword_packer
    import crcp_pkg::*;
#(
    parameter int MAX_GEN_BITS = DEF_MAX_GEN_BITS,
    parameter int COUNT_BITS   = DEF_COUNT_BITS,
    parameter int CFG_W        = (MAX_GEN_BITS > COUNT_BITS) ? MAX_GEN_BITS : COUNT_BITS
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,

    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [7:0]       s_axis_tdata,     // [7:0] data_byte

    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic      [7:0]       m_axis_tdata,     // [7:0] out_byte
    output logic                  m_axis_tuser,     // [0] is_header
    output logic                  m_axis_tlast,

    input  wire logic             cfg_wr_en,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [CFG_W-1:0] cfg_wdata
);

    localparam int GLW      = $clog2(MAX_GEN_BITS + 1);
    localparam int REM_BITS = MAX_GEN_BITS - 1;
    localparam int SW       = 2 * BYTE_BITS - 1 + 2 * REM_BITS;
    localparam int MAXB     = SW / BYTE_BITS;
    localparam int NBW      = $clog2(MAXB + 2);

    logic [MAX_GEN_BITS-1:0] gen_poly_reg;
    logic [GLW-1:0]          gen_len_reg;
    logic                    word_mode_reg;
    logic [COUNT_BITS-1:0]   byte_count_reg;

    logic [6:0]              acc_reg;
    logic [2:0]              cnt_reg;
    logic [COUNT_BITS-1:0]   seen_reg;
    logic [COUNT_BITS-1:0]   seen_inc;
    logic [COUNT_BITS-1:0]   seen_next;

    logic                    in_valid_reg;
    logic [7:0]              in_data_reg;

    logic                    ob_valid_reg;
    logic [MAXB:0][7:0]      ob_buf_reg;
    logic [NBW-1:0]          ob_left_reg;
    logic                    ob_hdr_reg;

    logic                    start;
    logic [MAXB:0][7:0]      res_bytes;
    logic [NBW-1:0]          res_count;
    logic [6:0]              acc_next;
    logic [2:0]              cnt_next;
    logic                    take;
    logic                    ob_done;
    logic                    move;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_poly_reg   <= MAX_GEN_BITS'(RST_GEN_POLY);
            gen_len_reg    <= GLW'(RST_GEN_LEN);
            word_mode_reg  <= 1'(RST_WORD_MODE);
            byte_count_reg <= COUNT_BITS'(RST_BYTE_COUNT);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_GEN_POLY:   gen_poly_reg   <= cfg_wdata[MAX_GEN_BITS-1:0];
                REG_GEN_LEN:    gen_len_reg    <= cfg_wdata[GLW-1:0];
                REG_WORD_MODE:  word_mode_reg  <= cfg_wdata[0];
                REG_BYTE_COUNT: byte_count_reg <= cfg_wdata[COUNT_BITS-1:0];
                default:        ;
            endcase
        end
    end

    assign start = (seen_reg == '0);

    crcp_encode #(
        .MAX_GEN_BITS (MAX_GEN_BITS)
    ) u_encode (
        .gen_poly  (gen_poly_reg),
        .gen_len   (gen_len_reg),
        .word_mode (word_mode_reg),
        .start     (start),
        .bc_lo     (byte_count_reg[2:0]),
        .acc_in    (acc_reg),
        .cnt_in    (cnt_reg),
        .data_byte (in_data_reg),
        .res_bytes (res_bytes),
        .res_count (res_count),
        .acc_out   (acc_next),
        .cnt_out   (cnt_next)
    );

    assign take    = ob_valid_reg && m_axis_tready;
    assign ob_done = take && (ob_left_reg == NBW'(1));
    // every item yields at least one byte, so it needs a free buffer
    assign move    = in_valid_reg && (!ob_valid_reg || ob_done);

    assign s_axis_tready = !in_valid_reg || move;

    assign seen_inc  = seen_reg + COUNT_BITS'(1);
    assign seen_next = (seen_inc == byte_count_reg) ? '0 : seen_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            ob_valid_reg <= 1'b0;
            ob_left_reg  <= '0;
            ob_hdr_reg   <= 1'b0;
            acc_reg      <= '0;
            cnt_reg      <= '0;
            seen_reg     <= '0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;

            if (move)
            begin
                ob_valid_reg <= 1'b1;
                ob_left_reg  <= res_count;
                ob_hdr_reg   <= start;
                acc_reg      <= acc_next;
                cnt_reg      <= cnt_next;
                seen_reg     <= seen_next;
            end
            else if (take)
            begin
                ob_valid_reg <= !ob_done;
                ob_left_reg  <= ob_left_reg - NBW'(1);
                ob_hdr_reg   <= 1'b0;
            end
        end
    end

    // payload: no reset
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            in_data_reg <= s_axis_tdata;

        if (move)
            ob_buf_reg <= res_bytes;
        else if (take)
        begin
            for (int k = 0; k < MAXB; k++)
                ob_buf_reg[k] <= ob_buf_reg[k+1];
        end
    end

    assign m_axis_tvalid = ob_valid_reg;
    assign m_axis_tdata  = ob_buf_reg[0];
    assign m_axis_tuser  = ob_hdr_reg;
    assign m_axis_tlast  = (ob_left_reg == NBW'(1));

`ifndef SYNTHESIS
    // a loaded buffer always has bytes left to send
    a_buf_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        ob_valid_reg |-> (ob_left_reg != '0))
        else $error("output buffer valid with no bytes left");

    // an item that opens a stream leads with a header byte
    a_hdr_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        (move && start) |=> (ob_hdr_reg && ob_valid_reg))
        else $error("stream start without header");

    // the header is only ever the first byte of an item
    a_hdr_once: assert property (@(posedge clk) disable iff (!rst_n)
        (take && m_axis_tuser && !m_axis_tlast && !move) |=> !m_axis_tuser)
        else $error("header flag held past first byte");

    // the input stage never takes an item while a full one is stuck
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !move) |=> ($stable(in_data_reg) && in_valid_reg))
        else $error("input stage overwritten");
`endif

endmodule

`default_nettype wire
